@@ hw/rtl/dvms_pkg.sv @@
// Shared types, constants and fixed-point helpers for the damped Verlet motion step unit.
package dvms_pkg;

  // Fraction bits of position, velocity, acceleration and force words
  localparam int unsigned FRAC_BITS = 16;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned LANES  = 3;
  localparam int unsigned PROD_W = 66;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TIME_STEP    = 3'd0,
    REG_DAMPING      = 3'd1,
    REG_INVERSE_MASS = 3'd2,
    REG_START_X      = 3'd3,
    REG_START_Y      = 3'd4,
    REG_START_Z      = 3'd5
  } reg_idx_t;

  localparam logic [15:0] TIME_STEP_RST    = 16'd1092;
  localparam logic [15:0] DAMPING_RST      = 16'd62259;
  localparam logic [30:0] INVERSE_MASS_RST = 31'd6554;
  localparam word_t       START_RST        = 32'sd0;

  // Settings shared by all lanes
  typedef struct packed {
    logic [15:0] dt;
    logic [15:0] damp;
    logic [30:0] inv_mass;
  } lane_cfg_t;

  // Per-lane control from the top level
  typedef struct packed {
    logic  start;
    logic  load;
    word_t load_val;
  } lane_ctl_t;

  // Per-lane status back to the top level
  typedef struct packed {
    logic  done;
    word_t pos;
  } lane_res_t;

  // Arithmetic right shift with round half up
  function automatic prod_t rnd_shift(input prod_t x, input int unsigned s);
    prod_t half;
    half = prod_t'(1) <<< (s - 1);
    return (x + half) >>> s;
  endfunction

  // Clamp to the signed 32-bit range
  function automatic word_t sat32(input prod_t x);
    prod_t hi;
    prod_t lo;
    hi = prod_t'(32'sh7FFF_FFFF);
    lo = prod_t'(32'sh8000_0000);
    if (x > hi) begin
      return 32'sh7FFF_FFFF;
    end else if (x < lo) begin
      return 32'sh8000_0000;
    end
    return x[WORD_W-1:0];
  endfunction

endpackage

@@ hw/rtl/damped_verlet_motion_step_unit.sv @@
// Top level: configuration registers, tick control, three axis lanes, result stage.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+----------------------------------
//   in      | input     | in_valid / in_ready   | in_force_x, in_force_y, in_force_z
//   out     | output    | out_valid / out_ready | out_pos_x, out_pos_y, out_pos_z
//   cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// A tick runs from request to result through acceptance, the lanes (six
// multiplies on each lane's single multiplier plus writeback), and a move
// of the positions into the output register.
// Reset (rst_n low, synchronous) restores the register defaults, zeroes
// velocity and acceleration, and sets position to the start value.
// A stalled output holds its request; the next tick is still accepted and
// runs, then waits in the lanes until the output register frees.
// cfg_ready is always high; start writes load that axis position at once.
module damped_verlet_motion_step_unit (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  dvms_pkg::word_t in_force_x,
  input  dvms_pkg::word_t in_force_y,
  input  dvms_pkg::word_t in_force_z,
  output logic            out_valid,
  input  logic            out_ready,
  output dvms_pkg::word_t out_pos_x,
  output dvms_pkg::word_t out_pos_y,
  output dvms_pkg::word_t out_pos_z,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [2:0]      cfg_index,
  input  logic [31:0]     cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_PUSH
  } state_t;

  state_t              state_r;
  logic [15:0]         time_step_r;
  logic [15:0]         damping_r;
  logic [30:0]         inv_mass_r;

  logic                in_acc;
  logic                cfg_acc;
  logic                merge_free;
  logic                merge_load;
  logic [dvms_pkg::LANES-1:0] lane_done;
  dvms_pkg::lane_cfg_t lane_cfg;
  dvms_pkg::lane_ctl_t lane_ctl [dvms_pkg::LANES];
  dvms_pkg::lane_res_t lane_res [dvms_pkg::LANES];
  dvms_pkg::word_t     lane_force [dvms_pkg::LANES];
  dvms_pkg::reg_idx_t  start_idx [dvms_pkg::LANES];

  assign in_ready   = (state_r == ST_IDLE);
  assign in_acc     = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign cfg_acc    = cfg_valid && cfg_ready;
  assign merge_load = (state_r == ST_PUSH) && merge_free;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r <= dvms_pkg::TIME_STEP_RST;
      damping_r   <= dvms_pkg::DAMPING_RST;
      inv_mass_r  <= dvms_pkg::INVERSE_MASS_RST;
    end else if (cfg_acc) begin
      if (cfg_index == dvms_pkg::REG_TIME_STEP) begin
        time_step_r <= cfg_data[15:0];
      end
      if (cfg_index == dvms_pkg::REG_DAMPING) begin
        damping_r <= cfg_data[15:0];
      end
      if (cfg_index == dvms_pkg::REG_INVERSE_MASS) begin
        inv_mass_r <= cfg_data[30:0];
      end
    end
  end

  assign lane_cfg.dt       = time_step_r;
  assign lane_cfg.damp     = damping_r;
  assign lane_cfg.inv_mass = inv_mass_r;

  assign lane_force[0] = in_force_x;
  assign lane_force[1] = in_force_y;
  assign lane_force[2] = in_force_z;
  assign start_idx[0]  = dvms_pkg::REG_START_X;
  assign start_idx[1]  = dvms_pkg::REG_START_Y;
  assign start_idx[2]  = dvms_pkg::REG_START_Z;

  // Tick control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (lane_done[0]) begin
            state_r <= ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (merge_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Axis lanes
  for (genvar g = 0; g < dvms_pkg::LANES; g++) begin : g_lane
    assign lane_ctl[g].start    = in_acc;
    assign lane_ctl[g].load     = cfg_acc && (cfg_index == start_idx[g]);
    assign lane_ctl[g].load_val = cfg_data;
    assign lane_done[g]         = lane_res[g].done;

    dvms_lane u_lane (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (lane_ctl[g]),
      .cfg_i   (lane_cfg),
      .force_i (lane_force[g]),
      .res_o   (lane_res[g])
    );
  end

  dvms_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load_i    (merge_load),
    .res_i     (lane_res),
    .free_o    (merge_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_pos_x (out_pos_x),
    .out_pos_y (out_pos_y),
    .out_pos_z (out_pos_z)
  );

  // Lanes run in lockstep
  a_lanes_sync: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (&lane_done))
    else $error("lanes finished out of step");

  // A lane finishes only inside a running tick
  a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    (|lane_done) |-> (state_r == ST_RUN))
    else $error("lane finished outside a tick");

  // Accepting a tick closes the input until it is pushed out
  a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input reopened during a tick");

  // Results enter the output register only when it has room
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    merge_load |=> out_valid)
    else $error("result push lost");

endmodule

@@ hw/rtl/dvms_lane.sv @@
// One axis lane: motion state and a shared multiplier stepped through the tick.
module dvms_lane (
  input  logic              clk,
  input  logic              rst_n,
  input  dvms_pkg::lane_ctl_t ctl_i,
  input  dvms_pkg::lane_cfg_t cfg_i,
  input  dvms_pkg::word_t   force_i,
  output dvms_pkg::lane_res_t res_o
);

  // Multiplier schedule; each product is registered and written back in the cycle
  // after its multiply, so a dependent operation must come after that writeback.
  typedef enum logic [2:0] {
    C_VD,   // v * damping
    C_DT2,  // dt * dt
    C_FM,   // force * inverse_mass
    C_VT,   // v1 * dt
    C_AT2,  // a_old * dt^2
    C_DV    // (a_old + a_new) * dt
  } cyc_t;

  logic                   run_r;
  cyc_t                   cyc_r;
  logic                   wb_vld_r;
  cyc_t                   wb_op_r;
  dvms_pkg::prod_t        prod_r;
  dvms_pkg::word_t        force_r;
  dvms_pkg::word_t        pos_r;
  dvms_pkg::word_t        vel_r;
  dvms_pkg::word_t        acc_r;
  dvms_pkg::word_t        v1_r;
  dvms_pkg::word_t        anew_r;
  logic [31:0]            dt2_r;
  logic signed [32:0]     t1_r;

  logic signed [32:0]     op_a;
  logic signed [32:0]     op_b;
  dvms_pkg::prod_t        prod_nxt;
  cyc_t                   cyc_nxt;
  dvms_pkg::prod_t        rnd16;
  dvms_pkg::prod_t        rnd17;
  dvms_pkg::prod_t        rnd33;
  dvms_pkg::prod_t        rndf;
  dvms_pkg::prod_t        pos_sum;
  dvms_pkg::prod_t        vel_sum;

  // Operand select for the current slot
  always_comb begin
    op_a = '0;
    op_b = '0;
    unique case (cyc_r)
      C_VD: begin
        op_a = {vel_r[31], vel_r};
        op_b = {17'b0, cfg_i.damp};
      end
      C_DT2: begin
        op_a = {17'b0, cfg_i.dt};
        op_b = {17'b0, cfg_i.dt};
      end
      C_FM: begin
        op_a = {force_r[31], force_r};
        op_b = {2'b0, cfg_i.inv_mass};
      end
      C_VT: begin
        op_a = {v1_r[31], v1_r};
        op_b = {17'b0, cfg_i.dt};
      end
      C_AT2: begin
        op_a = {acc_r[31], acc_r};
        op_b = {1'b0, dt2_r};
      end
      C_DV: begin
        op_a = {acc_r[31], acc_r} + {anew_r[31], anew_r};
        op_b = {17'b0, cfg_i.dt};
      end
      default: begin
        op_a = '0;
        op_b = '0;
      end
    endcase
  end

  assign prod_nxt = dvms_pkg::prod_t'(op_a) * dvms_pkg::prod_t'(op_b);

  // Next slot
  always_comb begin
    unique case (cyc_r)
      C_VD:    cyc_nxt = C_DT2;
      C_DT2:   cyc_nxt = C_FM;
      C_FM:    cyc_nxt = C_VT;
      C_VT:    cyc_nxt = C_AT2;
      C_AT2:   cyc_nxt = C_DV;
      C_DV:    cyc_nxt = C_VD;
      default: cyc_nxt = C_VD;
    endcase
  end

  // Writeback arithmetic on the registered product
  always_comb begin
    rnd16   = dvms_pkg::rnd_shift(prod_r, 16);
    rnd17   = dvms_pkg::rnd_shift(prod_r, 17);
    rnd33   = dvms_pkg::rnd_shift(prod_r, 33);
    rndf    = dvms_pkg::rnd_shift(prod_r, dvms_pkg::FRAC_BITS);
    pos_sum = dvms_pkg::prod_t'(pos_r) + dvms_pkg::prod_t'(t1_r) + rnd33;
    vel_sum = dvms_pkg::prod_t'(v1_r) + rnd17;
  end

  // Sequencer and multiplier register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      cyc_r    <= C_VD;
      wb_vld_r <= 1'b0;
      wb_op_r  <= C_VD;
    end else begin
      wb_vld_r <= run_r;
      wb_op_r  <= cyc_r;
      if (ctl_i.start) begin
        run_r <= 1'b1;
        cyc_r <= C_VD;
      end else if (run_r) begin
        cyc_r <= cyc_nxt;
        if (cyc_r == C_DV) begin
          run_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    if (ctl_i.start) begin
      force_r <= force_i;
    end
  end

  // Intermediate terms of the tick
  always_ff @(posedge clk) begin
    if (wb_vld_r) begin
      unique case (wb_op_r)
        C_VD:    v1_r   <= dvms_pkg::sat32(rnd16);
        C_DT2:   dt2_r  <= prod_r[31:0];
        C_FM:    anew_r <= dvms_pkg::sat32(rndf);
        C_VT:    t1_r   <= rnd16[32:0];
        C_AT2:   ;
        C_DV:    ;
        default: ;
      endcase
    end
  end

  // Motion state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= dvms_pkg::START_RST;
      vel_r <= '0;
      acc_r <= '0;
    end else if (ctl_i.load) begin
      pos_r <= ctl_i.load_val;
    end else if (wb_vld_r && (wb_op_r == C_AT2)) begin
      pos_r <= dvms_pkg::sat32(pos_sum);
    end else if (wb_vld_r && (wb_op_r == C_DV)) begin
      vel_r <= dvms_pkg::sat32(vel_sum);
      acc_r <= anew_r;
    end
  end

  assign res_o.done = wb_vld_r && (wb_op_r == C_DV);
  assign res_o.pos  = pos_r;

endmodule

@@ hw/rtl/dvms_merge.sv @@
// Result stage: gathers the three lane positions into one output request.
module dvms_merge (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            load_i,
  input  dvms_pkg::lane_res_t res_i [dvms_pkg::LANES],
  output logic            free_o,
  output logic            out_valid,
  input  logic            out_ready,
  output dvms_pkg::word_t out_pos_x,
  output dvms_pkg::word_t out_pos_y,
  output dvms_pkg::word_t out_pos_z
);

  logic            valid_r;
  dvms_pkg::word_t pos_x_r;
  dvms_pkg::word_t pos_y_r;
  dvms_pkg::word_t pos_z_r;

  assign free_o = !valid_r || out_ready;

  // Output holding register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load_i) begin
      valid_r <= 1'b1;
    end else if (out_ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      pos_x_r <= res_i[0].pos;
      pos_y_r <= res_i[1].pos;
      pos_z_r <= res_i[2].pos;
    end
  end

  assign out_valid = valid_r;
  assign out_pos_x = pos_x_r;
  assign out_pos_y = pos_y_r;
  assign out_pos_z = pos_z_r;

endmodule

@@ sim/damped_verlet_motion_step_unit_test.sv @@
// Self-checking testbench for the damped Verlet motion step unit.
`timescale 1ns / 100ps

module damped_verlet_motion_step_unit_test;

  // Wide signed intermediate, big enough for a_old * dt * dt plus rounding
  typedef logic signed [79:0] wide_t;

  typedef struct packed {
    dvms_pkg::word_t x;
    dvms_pkg::word_t y;
    dvms_pkg::word_t z;
  } pos_vec_t;

  typedef struct packed {
    logic [2:0]  idx;
    logic [31:0] data;
  } reg_write_t;

  // Indexes the block does not map; writes to them must be ignored
  localparam logic [2:0] REG_UNMAPPED_A = 3'd6;
  localparam logic [2:0] REG_UNMAPPED_B = 3'd7;

  localparam wide_t WORD_MAX = 80'sh7FFF_FFFF;
  localparam wide_t WORD_MIN = -80'sh8000_0000;

  localparam int STALL_LIMIT = 4000;
  localparam int SETTLE_CYCLES = 20;

  // Predicts each position from the force requests and register writes
  class verlet_scoreboard;
    logic [15:0] dt;
    logic [15:0] damp;
    logic [30:0] inv_mass;
    dvms_pkg::word_t position [3];
    dvms_pkg::word_t velocity [3];
    dvms_pkg::word_t accel [3];
    pos_vec_t pending_pos [$];
    int unsigned fails = 0;
    int unsigned checked = 0;

    function void reset_state();
      dt = dvms_pkg::TIME_STEP_RST;
      damp = dvms_pkg::DAMPING_RST;
      inv_mass = dvms_pkg::INVERSE_MASS_RST;
      for (int i = 0; i < 3; i++) begin
        position[i] = dvms_pkg::START_RST;
        velocity[i] = '0;
        accel[i] = '0;
      end
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
      case (idx)
        dvms_pkg::REG_TIME_STEP:    dt = data[15:0];
        dvms_pkg::REG_DAMPING:      damp = data[15:0];
        dvms_pkg::REG_INVERSE_MASS: inv_mass = data[30:0];
        dvms_pkg::REG_START_X:      position[0] = data;
        dvms_pkg::REG_START_Y:      position[1] = data;
        dvms_pkg::REG_START_Z:      position[2] = data;
        default: ;
      endcase
    endfunction

    // Shift right with round half up
    function wide_t rescale(wide_t v, int unsigned s);
      return (v + (wide_t'(1) <<< (s - 1))) >>> s;
    endfunction

    function dvms_pkg::word_t clamp_word(wide_t v);
      if (v > WORD_MAX) begin
        return 32'sh7FFF_FFFF;
      end else if (v < WORD_MIN) begin
        return 32'sh8000_0000;
      end
      return v[31:0];
    endfunction

    // One tick on one axis; returns the new position
    function dvms_pkg::word_t advance_axis(int ax, dvms_pkg::word_t force_in);
      wide_t dtw;
      wide_t dampw;
      wide_t invw;
      wide_t f;
      wide_t p0;
      wide_t v0;
      wide_t v1;
      wide_t a_old;
      wide_t a_new;
      wide_t dp;
      wide_t dv;
      dtw = dt;
      dampw = damp;
      invw = inv_mass;
      f = force_in;
      p0 = position[ax];
      v0 = velocity[ax];
      a_old = accel[ax];
      v1 = clamp_word(rescale(v0 * dampw, 16));
      dp = rescale(v1 * dtw, 16) + rescale(a_old * dtw * dtw, 33);
      position[ax] = clamp_word(p0 + dp);
      accel[ax] = clamp_word(rescale(f * invw, dvms_pkg::FRAC_BITS));
      a_new = accel[ax];
      dv = rescale((a_old + a_new) * dtw, 17);
      velocity[ax] = clamp_word(v1 + dv);
      return position[ax];
    endfunction

    function void note_force(dvms_pkg::word_t fx, dvms_pkg::word_t fy, dvms_pkg::word_t fz);
      pos_vec_t e;
      e.x = advance_axis(0, fx);
      e.y = advance_axis(1, fy);
      e.z = advance_axis(2, fz);
      pending_pos = {pending_pos, e};
    endfunction

    function void check_pos(dvms_pkg::word_t px, dvms_pkg::word_t py, dvms_pkg::word_t pz);
      pos_vec_t e;
      if (pending_pos.size() == 0) begin
        $error("position result with no request pending: x=%0d y=%0d z=%0d", px, py, pz);
        fails++;
        return;
      end
      e = pending_pos.pop_front();
      checked++;
      if (px !== e.x) begin
        $error("pos_x: expected %0d, got %0d", e.x, px);
        fails++;
      end
      if (py !== e.y) begin
        $error("pos_y: expected %0d, got %0d", e.y, py);
        fails++;
      end
      if (pz !== e.z) begin
        $error("pos_z: expected %0d, got %0d", e.z, pz);
        fails++;
      end
    endfunction
  endclass

  logic            clk;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  dvms_pkg::word_t in_force_x = '0;
  dvms_pkg::word_t in_force_y = '0;
  dvms_pkg::word_t in_force_z = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  dvms_pkg::word_t out_pos_x;
  dvms_pkg::word_t out_pos_y;
  dvms_pkg::word_t out_pos_z;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [2:0]      cfg_index = '0;
  logic [31:0]     cfg_data = '0;

  verlet_scoreboard sb;
  reg_write_t reg_writes [$];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int stall_cycles = 0;
  int sent = 0;
  int settings_applied = 0;

  damped_verlet_motion_step_unit u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_force_x (in_force_x),
    .in_force_y (in_force_y),
    .in_force_z (in_force_z),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_pos_x  (out_pos_x),
    .out_pos_y  (out_pos_y),
    .out_pos_z  (out_pos_z),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_pos(out_pos_x, out_pos_y, out_pos_z);
    end
  end

  // Watchdog: cycles with no request moving on any channel
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request accepted for %0d cycles", STALL_LIMIT);
      $display("damped_verlet_motion_step_unit_test: FAIL");
      $finish;
    end
  end

  // Send one force request; valid stays high for a following request
  task automatic drive_force(dvms_pkg::word_t fx, dvms_pkg::word_t fy, dvms_pkg::word_t fz);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_force_x <= fx;
    in_force_y <= fy;
    in_force_z <= fz;
    do @(posedge clk); while (!in_ready);
    sb.note_force(fx, fy, fz);
    sent++;
  endtask

  task automatic finish_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drained();
    while (sb.pending_pos.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic queue_write(logic [2:0] idx, logic [31:0] data);
    reg_write_t w;
    w.idx = idx;
    w.data = data;
    reg_writes = {reg_writes, w};
  endtask

  // Apply queued register writes once the block has gone idle
  task automatic flush_regs();
    reg_write_t w;
    wait_drained();
    while (reg_writes.size() != 0) begin
      w = reg_writes.pop_front();
      cfg_valid <= 1'b1;
      cfg_index <= w.idx;
      cfg_data <= w.data;
      do @(posedge clk); while (!cfg_ready);
      sb.write_reg(w.idx, w.data);
    end
    cfg_valid <= 1'b0;
    @(posedge clk);
    settings_applied++;
  endtask

  // Mostly modest forces so the motion stays in range; some extremes
  function automatic dvms_pkg::word_t pick_force();
    int r;
    case ($urandom_range(9))
      0: return $urandom;
      1: return 32'sh7FFF_FFFF;
      2: return 32'sh8000_0000;
      3, 4: begin
        r = $urandom_range(0, 32'h003F_FFFF);
        return r - 32'sh0020_0000;
      end
      default: begin
        r = $urandom_range(0, 32'h03FF_FFFF);
        return r - 32'sh0200_0000;
      end
    endcase
  endfunction

  task automatic randomize_settings();
    logic [31:0] d;
    case ($urandom_range(5))
      0: d = 32'd1;
      1: d = 32'd65535;
      2: d = $urandom;
      default: d = $urandom_range(200, 4000);
    endcase
    queue_write(dvms_pkg::REG_TIME_STEP, d);
    case ($urandom_range(4))
      0: d = 32'd0;
      1: d = 32'd65535;
      2: d = $urandom;
      default: d = $urandom_range(55000, 65535);
    endcase
    queue_write(dvms_pkg::REG_DAMPING, d);
    case ($urandom_range(3))
      0: d = $urandom;
      1: d = 32'h7FFF_FFFF;
      default: d = $urandom_range(0, 32'h0004_0000);
    endcase
    queue_write(dvms_pkg::REG_INVERSE_MASS, d);
    if ($urandom_range(1)) begin
      queue_write(dvms_pkg::REG_START_X, $urandom);
      queue_write(dvms_pkg::REG_START_Y, $urandom_range(0, 32'h00FF_FFFF) - 32'h0080_0000);
      queue_write(dvms_pkg::REG_START_Z, $urandom);
    end
    if ($urandom_range(3) == 0) begin
      queue_write($urandom_range(1) ? REG_UNMAPPED_A : REG_UNMAPPED_B, $urandom);
    end
  endtask

  // Random forces; halfway the sender holds off until every position is back
  task automatic run_burst(int n);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        finish_burst();
        wait_drained();
      end
      drive_force(pick_force(), pick_force(), pick_force());
    end
    finish_burst();
  endtask

  int send_pcts [3] = '{37, 82, 0};
  int recv_pcts [3] = '{82, 37, 0};

  initial begin
    sb = new;
    sb.reset_state();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset defaults: zero, unit and extreme forces
    drive_force(32'sd0, 32'sd0, 32'sd0);
    drive_force(32'sh0001_0000, -32'sh0001_0000, 32'sh7FFF_FFFF);
    drive_force(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd1);
    finish_burst();

    // Half inverse mass so ties round up; upper data bits are don't-care
    queue_write(dvms_pkg::REG_TIME_STEP, 32'hFFFF_0444);
    queue_write(dvms_pkg::REG_INVERSE_MASS, 32'h8000_8000);
    flush_regs();
    drive_force(32'sd1, -32'sd1, 32'sd3);
    drive_force(-32'sd3, 32'sh7FFF_FFFF, -32'sd5);
    finish_burst();

    // Everything at the top end: accel, velocity and position saturate
    queue_write(dvms_pkg::REG_TIME_STEP, 32'h0000_FFFF);
    queue_write(dvms_pkg::REG_DAMPING, 32'h0000_FFFF);
    queue_write(dvms_pkg::REG_INVERSE_MASS, 32'h7FFF_FFFF);
    queue_write(dvms_pkg::REG_START_X, 32'h7FFF_FFFF);
    queue_write(dvms_pkg::REG_START_Y, 32'h8000_0000);
    queue_write(dvms_pkg::REG_START_Z, 32'h0000_0000);
    queue_write(REG_UNMAPPED_A, $urandom);
    queue_write(REG_UNMAPPED_B, $urandom);
    flush_regs();
    repeat (4) drive_force(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF);
    drive_force(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd0);
    finish_burst();

    // Zero damping wipes the incoming velocity each tick
    queue_write(dvms_pkg::REG_DAMPING, 32'd0);
    flush_regs();
    drive_force(pick_force(), pick_force(), pick_force());
    drive_force(pick_force(), pick_force(), pick_force());
    finish_burst();

    // Zero tick length: position holds still, velocity only decays by damping
    queue_write(dvms_pkg::REG_TIME_STEP, 32'd0);
    queue_write(dvms_pkg::REG_DAMPING, 32'd62259);
    flush_regs();
    drive_force(pick_force(), pick_force(), pick_force());
    drive_force(pick_force(), pick_force(), pick_force());
    finish_burst();

    // Smallest step, infinitely heavy body (zero inverse mass), fresh start
    queue_write(dvms_pkg::REG_TIME_STEP, 32'd1);
    queue_write(dvms_pkg::REG_INVERSE_MASS, 32'd0);
    queue_write(dvms_pkg::REG_START_X, $urandom);
    queue_write(dvms_pkg::REG_START_Y, $urandom);
    queue_write(dvms_pkg::REG_START_Z, $urandom);
    flush_regs();
    drive_force(pick_force(), pick_force(), pick_force());
    drive_force(pick_force(), pick_force(), pick_force());
    finish_burst();

    // Random part under three idle patterns, three settings each
    for (int ph = 0; ph < 3; ph++) begin
      for (int s = 0; s < 3; s++) begin
        randomize_settings();
        flush_regs();
        send_idle_pct = send_pcts[ph];
        recv_idle_pct = recv_pcts[ph];
        run_burst(61);
      end
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.pending_pos.size() != 0) begin
      $error("%0d position results never arrived", sb.pending_pos.size());
      sb.fails++;
    end
    $display("Run covered %0d force requests over %0d register settings,", sent,
             settings_applied);
    $display("with sender/receiver idling swapped and then off; %0d positions checked.",
             sb.checked);
    if (sb.fails == 0) begin
      $display("damped_verlet_motion_step_unit_test: PASS");
    end else begin
      $display("damped_verlet_motion_step_unit_test: FAIL");
    end
    $finish;
  end

endmodule
